FILE: rtl/odgs_pkg.sv
// Shared types, constants and helper functions of the gait scheduler.
package odgs_pkg;

    localparam int TICK_W           = 32;
    localparam int SEG_W            = 4;
    localparam int PHASE_W          = 16;
    localparam int PROG_W           = 17;
    localparam int CONTACT_W        = 64;
    localparam int LEGS             = 4;
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int N_W              = 5;
    localparam int P_W              = 10;
    localparam int OFF_W            = 4;
    localparam int DUR_W            = 5;
    localparam int TOT_W            = 14;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 20;
    localparam int OFFSETS_W        = 16;
    localparam int DURATIONS_W      = 20;
    localparam int QUEUE_DEPTH      = 4;
    localparam int NUM_DIV          = 9;
    localparam int RDIV_STAGES      = 8;
    localparam int RDIV_BITS        = 4;
    localparam int FDIV_STAGES      = 5;
    localparam int FDIV_BITS        = 4;
    localparam int IN_TDATA_W       = 32;
    localparam int OUT_TDATA_W      = 224;

    localparam logic [N_W-1:0] RST_SEGMENTS = 5'd10;
    localparam logic [P_W-1:0] RST_TICKS    = 10'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENTS  = 2'd0,
        CFG_TICKS     = 2'd1,
        CFG_OFFSETS   = 2'd2,
        CFG_DURATIONS = 2'd3
    } odgs_cfg_idx_t;

    typedef struct packed {
        logic [N_W-1:0]                  n;
        logic [P_W-1:0]                  p;
        logic [TOT_W-1:0]                total;
        logic [LEGS-1:0][OFF_W-1:0]      off;
        logic [LEGS-1:0][DUR_W-1:0]      dur;
        logic [LEGS-1:0][TOT_W-1:0]      st_start;
        logic [LEGS-1:0][TOT_W-1:0]      st_len;
        logic [LEGS-1:0][TOT_W-1:0]      sw_start;
        logic [LEGS-1:0][TOT_W-1:0]      sw_len;
    } odgs_sched_t;

    typedef struct packed {
        logic [TOT_W-1:0]  rem;
        logic [PROG_W-1:0] quo;
    } odgs_div_t;

    typedef struct packed {
        logic [SEG_W-1:0]              seg;
        logic [CONTACT_W-1:0]          contact_bits;
        logic [NUM_DIV-1:0]            kill;
        logic [NUM_DIV-1:0][TOT_W+PROG_W-1:0] div;
    } odgs_fstage_t;

    // One restoring step of the fraction divider: shift in a zero, subtract if it fits.
    function automatic odgs_div_t div_step(odgs_div_t d, logic [TOT_W-1:0] den);
        logic [TOT_W:0] t;
        odgs_div_t      o;
        t     = {d.rem, 1'b0};
        o.quo = {d.quo[PROG_W-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
            t        = t - {1'b0, den};
            o.quo[0] = 1'b1;
        end
        o.rem = t[TOT_W-1:0];
        return o;
    endfunction

endpackage

FILE: rtl/odgs_cfg.sv
// Configuration registers and the per-leg window bounds derived from them.
module odgs_cfg
    import odgs_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output odgs_sched_t           sched
);

    logic [N_W-1:0]         segments_reg;
    logic [P_W-1:0]         ticks_reg;
    logic [OFFSETS_W-1:0]   offsets_reg;
    logic [DURATIONS_W-1:0] durations_reg;

    logic [N_W-1:0]             n_reg, n_next;
    logic [P_W-1:0]             p_reg, p_next;
    logic [TOT_W-1:0]           total_reg, total_next;
    logic [LEGS-1:0][OFF_W-1:0] off_reg, off_next;
    logic [LEGS-1:0][DUR_W-1:0] dur_reg, dur_next;

    logic [LEGS-1:0][TOT_W-1:0] st_start_reg, st_start_next;
    logic [LEGS-1:0][TOT_W-1:0] st_len_reg, st_len_next;
    logic [LEGS-1:0][TOT_W-1:0] sw_start_reg, sw_start_next;
    logic [LEGS-1:0][TOT_W-1:0] sw_len_reg, sw_len_next;

    function automatic logic [OFF_W-1:0] mod_n(logic [OFF_W-1:0] v, logic [N_W-1:0] n);
        logic [N_W-1:0] r;
        r = '0;
        for (int k = OFF_W - 1; k >= 0; k--) begin
            r = {r[N_W-2:0], v[k]};
            if (r >= n) begin
                r = r - n;
            end
        end
        return r[OFF_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg  <= RST_SEGMENTS;
            ticks_reg     <= RST_TICKS;
            offsets_reg   <= '0;
            durations_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (odgs_cfg_idx_t'(cfg_index))
                CFG_SEGMENTS:  segments_reg  <= cfg_wdata[N_W-1:0];
                CFG_TICKS:     ticks_reg     <= cfg_wdata[P_W-1:0];
                CFG_OFFSETS:   offsets_reg   <= cfg_wdata[OFFSETS_W-1:0];
                CFG_DURATIONS: durations_reg <= cfg_wdata[DURATIONS_W-1:0];
                default:       ;
            endcase
        end
    end

    // First step: clamp the counts and reduce the per-leg fields.
    always_comb
    begin
        logic [N_W+P_W-1:0] prod;
        logic [DUR_W-1:0]   d;
        if (segments_reg == '0)
            n_next = N_W'(1);
        else if (segments_reg > N_W'(MAX_SEGMENTS))
            n_next = N_W'(MAX_SEGMENTS);
        else
            n_next = segments_reg;
        p_next     = (ticks_reg == '0) ? P_W'(1) : ticks_reg;
        prod       = {{P_W{1'b0}}, n_next} * {{N_W{1'b0}}, p_next};
        total_next = prod[TOT_W-1:0];
        for (int l = 0; l < LEGS; l++) begin
            off_next[l] = mod_n(offsets_reg[l*OFF_W +: OFF_W], n_next);
            d           = durations_reg[l*DUR_W +: DUR_W];
            dur_next[l] = (d > n_next) ? n_next : d;
        end
    end

    // Second step: window bounds in ticks.
    always_comb
    begin
        logic [N_W+P_W:0]   sp;
        logic [N_W+P_W-1:0] a;
        logic [N_W+P_W-1:0] b;
        logic [N_W+P_W-1:0] c;
        logic [N_W:0]       sum;
        for (int l = 0; l < LEGS; l++) begin
            a   = {{(N_W+1){1'b0}}, off_reg[l]} * {{N_W{1'b0}}, p_reg};
            b   = {{P_W{1'b0}}, dur_reg[l]} * {{N_W{1'b0}}, p_reg};
            c   = {{P_W{1'b0}}, n_reg - dur_reg[l]} * {{N_W{1'b0}}, p_reg};
            sum = {2'b00, off_reg[l]} + {1'b0, dur_reg[l]};
            sp  = {{P_W{1'b0}}, sum} * {{(N_W+1){1'b0}}, p_reg};
            if (sp >= {{(N_W+P_W+1-TOT_W){1'b0}}, total_reg})
                sp = sp - {{(N_W+P_W+1-TOT_W){1'b0}}, total_reg};
            st_start_next[l] = a[TOT_W-1:0];
            st_len_next[l]   = b[TOT_W-1:0];
            sw_len_next[l]   = c[TOT_W-1:0];
            sw_start_next[l] = sp[TOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        p_reg        <= p_next;
        total_reg    <= total_next;
        off_reg      <= off_next;
        dur_reg      <= dur_next;
        st_start_reg <= st_start_next;
        st_len_reg   <= st_len_next;
        sw_start_reg <= sw_start_next;
        sw_len_reg   <= sw_len_next;
    end

    assign sched.n        = n_reg;
    assign sched.p        = p_reg;
    assign sched.total    = total_reg;
    assign sched.off      = off_reg;
    assign sched.dur      = dur_reg;
    assign sched.st_start = st_start_reg;
    assign sched.st_len   = st_len_reg;
    assign sched.sw_start = sw_start_reg;
    assign sched.sw_len   = sw_len_reg;

endmodule

FILE: rtl/odgs_queue.sv
// Input side: accepts tick items into a short queue ahead of the datapath.
module odgs_queue
    import odgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  head_valid,
    output logic [TICK_W-1:0]     head_data,
    input  logic                  pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0][TICK_W-1:0] mem_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             take;

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign take       = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = take ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (take && !push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= s_tdata[TICK_W-1:0];
    end

endmodule

FILE: rtl/odgs_back.sv
// Datapath: cycle remainder, segment, windows, contact bits and fraction dividers.
module odgs_back
    import odgs_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  odgs_sched_t            sched,
    input  logic                   head_valid,
    input  logic [TICK_W-1:0]      head_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Remainder stages: tick mod total, four bits per stage.
    logic [RDIV_STAGES-1:0]             rv_reg;
    logic [RDIV_STAGES-1:0][TOT_W-1:0]  rrem_reg, rrem_next;
    logic [RDIV_STAGES-1:0][TICK_W-1:0] rbits_reg, rbits_next;
    logic [RDIV_STAGES-1:0]             adv_r;

    // Segment and window distance stage.
    logic                        v8_reg;
    logic [TOT_W-1:0]            r8_reg, r8_next;
    logic [SEG_W-1:0]            seg8_reg, seg8_next;
    logic [LEGS-1:0][TOT_W-1:0]  sq8_reg, sq8_next;
    logic [LEGS-1:0][TOT_W-1:0]  wq8_reg, wq8_next;
    logic [LEGS-1:0]             sk8_reg, sk8_next;
    logic [LEGS-1:0]             wk8_reg, wk8_next;
    logic                        adv8;

    // Fraction divider stages; the last one is the output register.
    logic [FDIV_STAGES-1:0]               fv_reg;
    odgs_fstage_t [FDIV_STAGES-1:0]       fst_reg, fst_next;
    logic [FDIV_STAGES-1:0]               adv_f;
    logic [NUM_DIV-1:0][TOT_W-1:0]        den;

    // Each stage moves when it is empty or the one after it moves.
    always_comb
    begin
        adv_f[FDIV_STAGES-1] = !fv_reg[FDIV_STAGES-1] || m_tready;
        for (int k = FDIV_STAGES - 2; k >= 0; k--)
            adv_f[k] = !fv_reg[k] || adv_f[k+1];
        adv8 = !v8_reg || adv_f[0];
        adv_r[RDIV_STAGES-1] = !rv_reg[RDIV_STAGES-1] || adv8;
        for (int k = RDIV_STAGES - 2; k >= 0; k--)
            adv_r[k] = !rv_reg[k] || adv_r[k+1];
    end

    assign pop = adv_r[0] && head_valid;

    always_comb
    begin
        logic [TOT_W-1:0]  rem;
        logic [TICK_W-1:0] bits;
        logic [TOT_W:0]    t;
        for (int k = 0; k < RDIV_STAGES; k++) begin
            if (k == 0) begin
                rem  = '0;
                bits = head_data;
            end
            else begin
                rem  = rrem_reg[k-1];
                bits = rbits_reg[k-1];
            end
            for (int j = 0; j < RDIV_BITS; j++) begin
                t    = {rem, bits[TICK_W-1]};
                bits = {bits[TICK_W-2:0], 1'b0};
                if (t >= {1'b0, sched.total})
                    t = t - {1'b0, sched.total};
                rem = t[TOT_W-1:0];
            end
            rrem_next[k]  = rem;
            rbits_next[k] = bits;
        end
    end

    // Segment index from the remainder, and each leg's distance into its windows.
    always_comb
    begin
        logic [TOT_W-1:0] x;
        logic [TOT_W-1:0] ps;
        logic [TOT_W:0]   q;
        logic [TOT_W-1:0] r;
        r         = rrem_reg[RDIV_STAGES-1];
        x         = r;
        seg8_next = '0;
        for (int k = SEG_W - 1; k >= 0; k--) begin
            ps = TOT_W'({{(TOT_W-P_W){1'b0}}, sched.p} << k);
            if (x >= ps) begin
                x            = x - ps;
                seg8_next[k] = 1'b1;
            end
        end
        r8_next = r;
        for (int l = 0; l < LEGS; l++) begin
            if (r >= sched.st_start[l])
                q = {1'b0, r} - {1'b0, sched.st_start[l]};
            else
                q = {1'b0, r} + {1'b0, sched.total} - {1'b0, sched.st_start[l]};
            sq8_next[l] = q[TOT_W-1:0];
            sk8_next[l] = (sched.st_len[l] == '0) || (q[TOT_W-1:0] > sched.st_len[l]);
            if (r >= sched.sw_start[l])
                q = {1'b0, r} - {1'b0, sched.sw_start[l]};
            else
                q = {1'b0, r} + {1'b0, sched.total} - {1'b0, sched.sw_start[l]};
            wq8_next[l] = q[TOT_W-1:0];
            wk8_next[l] = (sched.sw_len[l] == '0) || (q[TOT_W-1:0] > sched.sw_len[l]);
        end
    end

    always_comb
    begin
        den[0] = sched.total;
        for (int l = 0; l < LEGS; l++) begin
            den[1+l]      = sched.st_len[l];
            den[1+LEGS+l] = sched.sw_len[l];
        end
    end

    // Contact bits, divider set-up, then the divider steps of each stage.
    always_comb
    begin
        logic [N_W:0]      step;
        logic [N_W:0]      d;
        logic [TOT_W-1:0]  num;
        odgs_div_t         dv;
        for (int k = 0; k < FDIV_STAGES; k++) begin
            if (k == 0) begin
                fst_next[k].seg          = seg8_reg;
                fst_next[k].contact_bits = '0;
                for (int i = 0; i < MAX_SEGMENTS; i++) begin
                    for (int l = 0; l < LEGS; l++) begin
                        step = N_W'(i) + {2'b00, seg8_reg} + (N_W+1)'(1);
                        if (step >= {1'b0, sched.n})
                            step = step - {1'b0, sched.n};
                        if (step >= {2'b00, sched.off[l]})
                            d = step - {2'b00, sched.off[l]};
                        else
                            d = step + {1'b0, sched.n} - {2'b00, sched.off[l]};
                        fst_next[k].contact_bits[i*LEGS+l] =
                            ((N_W+1)'(i) < {1'b0, sched.n}) && (d < {1'b0, sched.dur[l]});
                    end
                end
                fst_next[k].kill[0] = 1'b0;
                for (int l = 0; l < LEGS; l++) begin
                    fst_next[k].kill[1+l]      = sk8_reg[l];
                    fst_next[k].kill[1+LEGS+l] = wk8_reg[l];
                end
                for (int u = 0; u < NUM_DIV; u++) begin
                    if (u == 0)
                        num = r8_reg;
                    else if (u <= LEGS)
                        num = sq8_reg[u-1];
                    else
                        num = wq8_reg[u-1-LEGS];
                    // A distance beyond its window is killed anyway, so the top bit is a compare.
                    dv.quo = '0;
                    dv.rem = num;
                    if (num >= den[u]) begin
                        dv.rem = num - den[u];
                        dv.quo = PROG_W'(1);
                    end
                    for (int j = 1; j < FDIV_BITS; j++)
                        dv = div_step(dv, den[u]);
                    fst_next[k].div[u] = dv;
                end
            end
            else begin
                fst_next[k] = fst_reg[k-1];
                for (int u = 0; u < NUM_DIV; u++) begin
                    dv = fst_reg[k-1].div[u];
                    for (int j = 0; j < FDIV_BITS; j++) begin
                        if (k < FDIV_STAGES - 1 || j == 0)
                            dv = div_step(dv, den[u]);
                    end
                    fst_next[k].div[u] = dv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
            v8_reg <= 1'b0;
            fv_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < RDIV_STAGES; k++) begin
                if (adv_r[k])
                    rv_reg[k] <= (k == 0) ? head_valid : rv_reg[k-1];
            end
            if (adv8)
                v8_reg <= rv_reg[RDIV_STAGES-1];
            for (int k = 0; k < FDIV_STAGES; k++) begin
                if (adv_f[k])
                    fv_reg[k] <= (k == 0) ? v8_reg : fv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RDIV_STAGES; k++) begin
            if (adv_r[k])
            begin
                rrem_reg[k]  <= rrem_next[k];
                rbits_reg[k] <= rbits_next[k];
            end
        end
        if (adv8)
        begin
            r8_reg   <= r8_next;
            seg8_reg <= seg8_next;
            sq8_reg  <= sq8_next;
            wq8_reg  <= wq8_next;
            sk8_reg  <= sk8_next;
            wk8_reg  <= wk8_next;
        end
        for (int k = 0; k < FDIV_STAGES; k++) begin
            if (adv_f[k])
                fst_reg[k] <= fst_next[k];
        end
    end

    odgs_fstage_t                   fo;
    logic [NUM_DIV-1:0][PROG_W-1:0] prog;

    assign fo = fst_reg[FDIV_STAGES-1];

    always_comb
    begin
        odgs_div_t dv;
        for (int u = 0; u < NUM_DIV; u++) begin
            dv      = fo.div[u];
            prog[u] = fo.kill[u] ? '0 : dv.quo;
        end
    end

    assign m_tvalid = fv_reg[FDIV_STAGES-1];
    assign m_tdata  = {
        {(OUT_TDATA_W - SEG_W - PHASE_W - 2*LEGS*PROG_W - CONTACT_W){1'b0}},
        fo.contact_bits,
        prog[8], prog[7], prog[6], prog[5],
        prog[4], prog[3], prog[2], prog[1],
        prog[0][PHASE_W-1:0],
        fo.seg
    };

endmodule

FILE: rtl/offset_duration_gait_scheduler_unit.sv
// Top level of the offset-duration gait scheduler.
// Throughput: one item per cycle while the output is ready; the 8-stage remainder
// pipeline and the 5-stage fraction dividers each retire one item a cycle, the four-entry
// queue absorbs stalls.
// Reset: configuration returns to 10 segments, 1 tick per segment, zero offsets and
// durations; the queue and all pipeline stages are emptied.
module offset_duration_gait_scheduler_unit
    import odgs_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Fields from bit 0: tick_index[31:0].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: segment_index[3:0], gait_phase[19:4],
    // stance_progress_leg0..3 (17 bits each, from bit 20),
    // swing_progress_leg0..3 (17 bits each, from bit 88),
    // contact_table[219:156], zero fill [223:220].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    odgs_sched_t           sched;
    logic                  head_valid;
    logic [TICK_W-1:0]     head_data;
    logic                  pop;

    // Configuration registers plus two register steps of derived window bounds.
    odgs_cfg #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sched     (sched)
    );

    // Front side: items land in the queue whenever it has room, so input
    // acceptance never waits directly on the output handshake.
    odgs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // Back side: an elastic pipeline where each stage advances when it is empty
    // or its successor advances, so bubbles close up under output stalls.
    odgs_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sched      (sched),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the offset-duration gait scheduler unit.
module tb_top;
    import odgs_pkg::*;

    // Bit position and width of each result field in the output tdata word.
    localparam int NUM_FIELDS = 11;
    localparam int FIELD_LO [NUM_FIELDS] = '{0, 4, 20, 37, 54, 71, 88, 105, 122, 139, 156};
    localparam int FIELD_W  [NUM_FIELDS] = '{4, 16, 17, 17, 17, 17, 17, 17, 17, 17, 64};
    localparam string FIELD_NAME [NUM_FIELDS] = '{"segment_index", "gait_phase",
        "stance0", "stance1", "stance2", "stance3",
        "swing0", "swing1", "swing2", "swing3", "contact_table"};

    localparam int NUM_PHASES   = 10;
    localparam int ITEMS_PHASE  = 193;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;

    typedef struct {
        logic [TICK_W-1:0]      tick;
        bit                     typed;
        logic [OUT_TDATA_W-1:0] result;
    } tick_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Shadow copy of the configuration registers, updated as they are written.
    logic [N_W-1:0]         sh_segments;
    logic [P_W-1:0]         sh_ticks;
    logic [OFFSETS_W-1:0]   sh_offsets;
    logic [DURATIONS_W-1:0] sh_durations;

    // Schedules still owed by the block, oldest first.
    logic [OUT_TDATA_W-1:0] pending_sched [$];

    int  mismatches;
    int  results_seen;
    bit  hold_req;
    bit  quiet;

    offset_duration_gait_scheduler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floored Q0.16 fraction num/den; a zero denominator gives zero.
    function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
        if (den == 0)
        begin
            return 0;
        end
        return (num * 65536) / den;
    endfunction

    // Progress through a window of len ticks that starts at start, wrapping around
    // the cycle of cyc ticks. Past the end of the window the progress is zero.
    function automatic longint unsigned window_frac(longint unsigned r, longint unsigned start,
                                                    longint unsigned len,
                                                    longint unsigned cyc);
        longint unsigned gap;
        if (len == 0)
        begin
            return 0;
        end
        gap = (r >= start) ? (r - start) : (r + cyc - start);
        if (gap > len)
        begin
            return 0;
        end
        return q16_ratio(gap, len);
    endfunction

    // Computes the full schedule word for one tick under the shadow configuration.
    function automatic logic [OUT_TDATA_W-1:0] gait_schedule(logic [TICK_W-1:0] tick);
        logic [OUT_TDATA_W-1:0] word;
        logic [CONTACT_W-1:0]   contact;
        longint unsigned        n, p, cyc, seg, r, off, dur, sw_start, step, gap;
        longint unsigned        stance, swing;
        word    = '0;
        contact = '0;
        n = sh_segments;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > DEF_MAX_SEGMENTS)
        begin
            n = DEF_MAX_SEGMENTS;
        end
        p = sh_ticks;
        if (p == 0)
        begin
            p = 1;
        end
        cyc = n * p;
        seg = (longint'(tick) / p) % n;
        r   = longint'(tick) % cyc;
        word[3:0]  = seg[3:0];
        word[19:4] = q16_ratio(r, cyc);
        for (int leg = 0; leg < LEGS; leg++)
        begin
            off = ((sh_offsets >> (OFF_W * leg)) & 4'hF) % n;
            dur = (sh_durations >> (DUR_W * leg)) & 5'h1F;
            if (dur > n)
            begin
                dur = n;
            end
            stance = window_frac(r, off * p, dur * p, cyc);
            sw_start = (off + dur) * p;
            if (sw_start > cyc)
            begin
                sw_start -= cyc;
            end
            if (sw_start == cyc)
            begin
                sw_start = 0;
            end
            swing = window_frac(r, sw_start, (n - dur) * p, cyc);
            word[20 + PROG_W * leg +: PROG_W] = stance[PROG_W-1:0];
            word[88 + PROG_W * leg +: PROG_W] = swing[PROG_W-1:0];
            for (int i = 0; i < n; i++)
            begin
                step = (i + seg + 1) % n;
                gap = (step >= off) ? (step - off) : (step + n - off);
                if (gap < dur)
                begin
                    contact[i * LEGS + leg] = 1'b1;
                end
            end
        end
        word[219:156] = contact;
        return word;
    endfunction

    // Offers one tick and waits until the block takes it, then records what it owes.
    task automatic offer_tick(logic [TICK_W-1:0] tick, bit typed, logic [OUT_TDATA_W-1:0] res);
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_sched.push_back(typed ? res : gait_schedule(tick));
    endtask

    // Lowers valid, waits for every owed result and lets the pipeline go quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_sched.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes one register, then waits with the write enable low before returning.
    task automatic write_reg(odgs_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SEGMENTS:  sh_segments  = val[N_W-1:0];
            CFG_TICKS:     sh_ticks     = val[P_W-1:0];
            CFG_OFFSETS:   sh_offsets   = val[OFFSETS_W-1:0];
            CFG_DURATIONS: sh_durations = val[DURATIONS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Picks a tick that mostly lands in the first few cycles, so that window starts,
    // window ends and wraparound are hit often, with some full-range values.
    function automatic logic [TICK_W-1:0] pick_tick();
        int unsigned n, p, cyc;
        n = (sh_segments == 0) ? 1 : ((sh_segments > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS
                                                                        : sh_segments);
        p = (sh_ticks == 0) ? 1 : sh_ticks;
        cyc = n * p;
        case ($urandom_range(0, 9))
            6, 9:    return $urandom();
            7:       return 32'hFFFF_FFFF - $urandom_range(0, cyc);
            8:       return $urandom_range(0, 3 * n) * p;
            default: return $urandom_range(0, 3 * cyc);
        endcase
    endfunction

    // Result checker: every item taken from the block is held against the oldest
    // schedule still owed, one field at a time.
    always @(posedge clk)
    begin
        logic [OUT_TDATA_W-1:0] want;
        logic [63:0]            w_f, g_f;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_sched.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("tb_top: result with nothing owed, data %h", m_tdata);
                end
            end
            else
            begin
                want = pending_sched.pop_front();
                for (int f = 0; f < NUM_FIELDS; f++)
                begin
                    w_f = (want    >> FIELD_LO[f]) & ((65'd1 << FIELD_W[f]) - 1);
                    g_f = (m_tdata >> FIELD_LO[f]) & ((65'd1 << FIELD_W[f]) - 1);
                    if (w_f !== g_f)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("tb_top: result %0d field %s expected %h got %h",
                                     results_seen, FIELD_NAME[f], w_f, g_f);
                        end
                    end
                end
            end
        end
    end

    // Receiver: random ready bursts, one long hold-off on request, always ready
    // in the quiet closing part.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        tick_row_t reset_rows [$];
        logic [OUT_TDATA_W-1:0] at_max;
        logic [OUT_TDATA_W-1:0] at_nine;
        bit gaps;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SEGMENTS;
        cfg_wdata    = '0;
        rst_n        = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        hold_req     = 1'b0;
        quiet        = 1'b0;
        sh_segments  = RST_SEGMENTS;
        sh_ticks     = RST_TICKS;
        sh_offsets   = '0;
        sh_durations = '0;

        // After reset: ten segments of one tick, zero offsets and durations. No leg is
        // ever in stance, and every swing window spans the whole cycle, so swing
        // progress equals the gait phase.
        at_max  = {4'b0, 64'b0, {4{17'd32768}}, {4{17'd0}}, 16'd32768, 4'd5};
        at_nine = {4'b0, 64'b0, {4{17'd58982}}, {4{17'd0}}, 16'd58982, 4'd9};
        reset_rows = '{
            '{32'd0,           1'b1, '0},
            '{32'd9,           1'b1, at_nine},
            '{32'hFFFF_FFFF,   1'b1, at_max},
            '{32'd1,           1'b0, '0},
            '{32'd10,          1'b0, '0},
            '{32'h8000_0000,   1'b0, '0},
            '{32'h7FFF_FFFF,   1'b0, '0},
            '{32'h5555_5555,   1'b0, '0},
            '{32'hAAAA_AAAA,   1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_rows[k])
        begin
            offer_tick(reset_rows[k].tick, reset_rows[k].typed, reset_rows[k].result);
        end
        drain();

        // Small gait with two legs in full stance (no swing), one through a saturated duration,
        // one stance window that wraps past the cycle end, and an offset beyond N.
        write_reg(CFG_SEGMENTS, 20'd4);
        write_reg(CFG_TICKS, 20'd2);
        write_reg(CFG_OFFSETS, 20'h1530);
        write_reg(CFG_DURATIONS, {5'd31, 5'd0, 5'd2, 5'd4});
        for (int t = 0; t < 10; t++)
        begin
            offer_tick(t, 1'b0, '0);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // Segment count at the maximum, every other register at its top value.
                    write_reg(CFG_SEGMENTS, 20'd16);
                    write_reg(CFG_TICKS, 20'd1023);
                    write_reg(CFG_OFFSETS, 20'hFFFF);
                    write_reg(CFG_DURATIONS, 20'hFFFFF);
                end
                1:
                begin
                    // Zero segment count and zero tick count both read as one.
                    write_reg(CFG_SEGMENTS, 20'd0);
                    write_reg(CFG_TICKS, 20'd0);
                    write_reg(CFG_OFFSETS, 20'h0000);
                    write_reg(CFG_DURATIONS, 20'h00000);
                end
                2:
                begin
                    // Segment count above the maximum saturates to sixteen.
                    write_reg(CFG_SEGMENTS, 20'd31);
                    write_reg(CFG_TICKS, 20'd3);
                    write_reg(CFG_OFFSETS, $urandom_range(0, 16'hFFFF));
                    write_reg(CFG_DURATIONS, {5'd16, 5'd0, 5'd8, 5'd17});
                end
                default:
                begin
                    write_reg(CFG_SEGMENTS, $urandom_range(1, 16));
                    write_reg(CFG_TICKS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                                     : $urandom_range(1, 12));
                    write_reg(CFG_OFFSETS, $urandom_range(0, 16'hFFFF));
                    write_reg(CFG_DURATIONS, $urandom_range(0, 20'hFFFFF) &
                                             {4{($urandom_range(0, 1) != 0) ? 5'h1F : 5'h0F}});
                end
            endcase

            quiet = (ph == NUM_PHASES - 1);
            gaps  = !quiet && ($urandom_range(0, 3) != 0);
            // In one phase the receiver stops for a long stretch while ticks keep
            // coming, so the queue fills and the input backs up.
            if (ph == 3)
            begin
                hold_req = 1'b1;
                gaps     = 1'b0;
            end

            for (int k = 0; k < ITEMS_PHASE; k++)
            begin
                // Halfway through one phase the sender waits for every result.
                if (ph == 5 && k == ITEMS_PHASE / 2)
                begin
                    s_tvalid <= 1'b0;
                    wait (pending_sched.size() == 0);
                    @(posedge clk);
                end
                if (gaps && $urandom_range(0, 5) == 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge clk);
                end
                offer_tick(pick_tick(), 1'b0, '0);
            end
            drain();
        end

        if (pending_sched.size() != 0)
        begin
            mismatches++;
        end
        $display("tb_top: %0d schedules checked over reset, small-gait, extreme and", results_seen);
        $display("tb_top: random register settings, with stalls and a long output hold-off.");
        if (mismatches == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: %0d mismatches", mismatches);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
